### sv/gjd_pkg.sv
// Shared types, constants and table functions for the Gregorian to Jalali date converter.
package gjd_pkg;

    localparam logic [18:0] DAY_OFFSET      = 19'd355666;
    localparam logic [13:0] BLOCK33_DAYS    = 14'd12053;
    localparam logic [10:0] BLOCK4_DAYS     = 11'd1461;
    localparam logic [8:0]  YEAR_DAYS       = 9'd365;
    localparam logic [10:0] YEAR_BASE_NEG   = 11'd1595;
    localparam logic [8:0]  FIRST_HALF_DAYS = 9'd186;

    // floor(x * RECIP >> SHIFT) == floor(x / divisor) over the operand ranges used here
    localparam logic [12:0] RECIP100      = 13'd5243;
    localparam int          RECIP100_SHIFT = 19;
    localparam logic [22:0] RECIP33       = 23'd5701442;
    localparam int          RECIP33_SHIFT  = 36;
    localparam logic [13:0] RECIP4        = 14'd11484;
    localparam int          RECIP4_SHIFT   = 24;

    typedef struct packed {
        logic valid;
        logic ok;
    } ctl_t;

    // Gregorian month start, day of year, zero based; month 1..12
    function automatic logic [8:0] greg_month_start(input logic [3:0] m);
        logic [8:0] s;
        case (m)
            4'd1:    s = 9'd0;
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // Jalali month start, day of year, zero based; month 1..12
    function automatic logic [8:0] jal_month_start(input logic [3:0] m);
        logic [8:0] s;
        case (m)
            4'd1:    s = 9'd0;
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd62;
            4'd4:    s = 9'd93;
            4'd5:    s = 9'd124;
            4'd6:    s = 9'd155;
            4'd7:    s = 9'd186;
            4'd8:    s = 9'd216;
            4'd9:    s = 9'd246;
            4'd10:   s = 9'd276;
            4'd11:   s = 9'd306;
            4'd12:   s = 9'd336;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

### sv/gjd_day_count.sv
// Two pipeline stages forming the absolute day count from a Gregorian date.
module gjd_day_count (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [13:0]         greg_year,
    input  logic [3:0]          greg_month,
    input  logic [4:0]          greg_day,
    output gjd_pkg::ctl_t       ctl_out,
    output logic [22:0]         days
);

    // stage 1
    gjd_pkg::ctl_t ctl1_reg, ctl1_next;
    logic [27:0]   p100_reg, p100_next;
    logic [27:0]   p400_reg, p400_next;
    logic [22:0]   gy365_reg, gy365_next;
    logic [12:0]   q4_reg, q4_next;
    logic [8:0]    base_reg, base_next;
    logic [14:0]   gy2;
    logic [14:0]   gy2_p3;

    // stage 2
    gjd_pkg::ctl_t ctl2_reg;
    logic [22:0]   days_reg, days_next;
    logic [23:0]   sum;

    always_comb
    begin
        ctl1_next.valid = in_valid;
        ctl1_next.ok    = (greg_month >= 4'd1) && (greg_month <= 4'd12) && (greg_day != 5'd0);
        gy2       = {1'b0, greg_year} + 15'(greg_month > 4'd2);
        gy2_p3    = gy2 + 15'd3;
        q4_next   = gy2_p3[14:2];
        p100_next = 28'(gy2 + 15'd99) * 28'(gjd_pkg::RECIP100);
        p400_next = 28'(gy2 + 15'd399) * 28'(gjd_pkg::RECIP100);
        gy365_next = 23'(greg_year) * 23'(gjd_pkg::YEAR_DAYS);
        base_next  = 9'(greg_day) + gjd_pkg::greg_month_start(greg_month);
    end

    always_comb
    begin
        sum = 24'(gjd_pkg::DAY_OFFSET) + 24'(gy365_reg) + 24'(q4_reg)
            - 24'(p100_reg[27:gjd_pkg::RECIP100_SHIFT])
            + 24'(p400_reg[27:gjd_pkg::RECIP100_SHIFT + 2])
            + 24'(base_reg);
        days_next = sum[22:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p100_reg  <= p100_next;
        p400_reg  <= p400_next;
        gy365_reg <= gy365_next;
        q4_reg    <= q4_next;
        base_reg  <= base_next;
        days_reg  <= days_next;
    end

    assign ctl_out = ctl2_reg;
    assign days    = days_reg;

endmodule

### sv/gjd_cycle_split.sv
// Four pipeline stages splitting the day count into 33-year and 4-year blocks.
module gjd_cycle_split (
    input  logic           clk,
    input  logic           rst_n,
    input  gjd_pkg::ctl_t  ctl_in,
    input  logic [22:0]    days,
    output gjd_pkg::ctl_t  ctl_out,
    output logic [9:0]     q33,
    output logic [3:0]     q4,
    output logic [10:0]    rem4
);

    gjd_pkg::ctl_t ctl3_reg, ctl4_reg, ctl5_reg, ctl6_reg;

    // stage 3: reciprocal product for /12053
    logic [45:0] prod33_reg, prod33_next;
    logic [22:0] days3_reg;

    // stage 4: quotient and remainder
    logic [9:0]  q33_4_reg, q33_4_next;
    logic [13:0] r33_reg, r33_next;
    logic [23:0] back33;

    // stage 5: reciprocal product for /1461
    logic [27:0] prod4_reg, prod4_next;
    logic [13:0] r33_5_reg;
    logic [9:0]  q33_5_reg;

    // stage 6
    logic [9:0]  q33_6_reg;
    logic [3:0]  q4_reg, q4_next;
    logic [10:0] r4_reg, r4_next;
    logic [13:0] back4;

    always_comb
    begin
        prod33_next = 46'(days) * 46'(gjd_pkg::RECIP33);
        q33_4_next  = prod33_reg[45:gjd_pkg::RECIP33_SHIFT];
        back33      = 24'(q33_4_next) * 24'(gjd_pkg::BLOCK33_DAYS);
        r33_next    = 14'(24'(days3_reg) - back33);
        prod4_next  = 28'(r33_reg) * 28'(gjd_pkg::RECIP4);
        q4_next     = prod4_reg[27:gjd_pkg::RECIP4_SHIFT];
        back4       = 14'(q4_next) * 14'(gjd_pkg::BLOCK4_DAYS);
        r4_next     = 11'(r33_5_reg - back4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
        end
        else
        begin
            ctl3_reg <= ctl_in;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod33_reg <= prod33_next;
        days3_reg  <= days;
        q33_4_reg  <= q33_4_next;
        r33_reg    <= r33_next;
        prod4_reg  <= prod4_next;
        r33_5_reg  <= r33_reg;
        q33_5_reg  <= q33_4_reg;
        q33_6_reg  <= q33_5_reg;
        q4_reg     <= q4_next;
        r4_reg     <= r4_next;
    end

    assign ctl_out = ctl6_reg;
    assign q33     = q33_6_reg;
    assign q4      = q4_reg;
    assign rem4    = r4_reg;

endmodule

### sv/gjd_year_month.sv
// Two pipeline stages forming Jalali year, day of year, month and day; output registers.
module gjd_year_month (
    input  logic           clk,
    input  logic           rst_n,
    input  gjd_pkg::ctl_t  ctl_in,
    input  logic [9:0]     q33,
    input  logic [3:0]     q4,
    input  logic [10:0]    rem4,
    output logic           done,
    output logic [14:0]    jal_year,
    output logic [3:0]     jal_month,
    output logic [4:0]     jal_day,
    output logic [8:0]     jal_day_of_year,
    output logic           input_ok
);

    // stage 7
    gjd_pkg::ctl_t ctl7_reg;
    logic [15:0]   jy_reg, jy_next;
    logic [8:0]    doy_reg, doy_next;
    logic [10:0]   t;
    logic [1:0]    yrs;
    logic [15:0]   acc;

    // stage 8
    logic          done_reg;
    logic          ok_reg, ok_next;
    logic [14:0]   year_reg, year_next;
    logic [3:0]    month_reg, month_next;
    logic [4:0]    day_reg, day_next;
    logic [8:0]    doy8_reg, doy8_next;
    logic [3:0]    m;
    logic [8:0]    mstart;

    always_comb
    begin
        t = rem4 - 11'd1;
        if (rem4 <= 11'(gjd_pkg::YEAR_DAYS))
        begin
            yrs      = 2'd0;
            doy_next = rem4[8:0];
        end
        else
        begin
            if (t >= 11'd1095)
                yrs = 2'd3;
            else if (t >= 11'd730)
                yrs = 2'd2;
            else if (t >= 11'd365)
                yrs = 2'd1;
            else
                yrs = 2'd0;
            doy_next = 9'(t - 11'(yrs) * 11'(gjd_pkg::YEAR_DAYS));
        end
        acc     = 16'(q33) * 16'd33 + {10'd0, q4, 2'b00} + 16'(yrs);
        jy_next = acc - 16'(gjd_pkg::YEAR_BASE_NEG);
    end

    always_comb
    begin
        m = 4'd1;
        for (int i = 2; i <= 12; i++)
        begin
            if (doy_reg >= gjd_pkg::jal_month_start(4'(i)))
                m = 4'(i);
        end
        mstart = gjd_pkg::jal_month_start(m);
        ok_next = ctl7_reg.ok;
        if (ctl7_reg.ok)
        begin
            year_next  = jy_reg[14:0];
            month_next = m;
            day_next   = 5'(doy_reg - mstart + 9'd1);
            doy8_next  = doy_reg;
        end
        else
        begin
            year_next  = '0;
            month_next = '0;
            day_next   = '0;
            doy8_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl7_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl7_reg <= ctl_in;
            done_reg <= ctl7_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        jy_reg    <= jy_next;
        doy_reg   <= doy_next;
        ok_reg    <= ok_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        doy8_reg  <= doy8_next;
    end

    assign done            = done_reg;
    assign jal_year        = year_reg;
    assign jal_month       = month_reg;
    assign jal_day         = day_reg;
    assign jal_day_of_year = doy8_reg;
    assign input_ok        = ok_reg;

endmodule

### sv/gregorian_to_jalali_date.sv
// Top level of the pipelined Gregorian to Jalali date converter.
//
//  channel   | handshake      | fields
//  ----------+----------------+----------------------------------------------------
//  request   | start / busy   | greg_year, greg_month, greg_day
//  result    | done (strobe)  | jal_year, jal_month, jal_day, jal_day_of_year, input_ok
//
// Eight register stages; a request enters every cycle and its result strobes
// on done after the day count, cycle split and year/month stages.
// busy is always low. Reset clears only the control bits and done;
// the pipe is empty after reset.
// The receiver cannot stall; results are shown for one cycle.
module gregorian_to_jalali_date (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [13:0]  greg_year,
    input  logic [3:0]   greg_month,
    input  logic [4:0]   greg_day,
    output logic         done,
    output logic [14:0]  jal_year,
    output logic [3:0]   jal_month,
    output logic [4:0]   jal_day,
    output logic [8:0]   jal_day_of_year,
    output logic         input_ok
);

    gjd_pkg::ctl_t ctl_a;
    gjd_pkg::ctl_t ctl_b;
    logic [22:0]   days;
    logic [9:0]    q33;
    logic [3:0]    q4;
    logic [10:0]   rem4;

    assign busy = 1'b0;

    gjd_day_count u_day_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start & ~busy),
        .greg_year  (greg_year),
        .greg_month (greg_month),
        .greg_day   (greg_day),
        .ctl_out    (ctl_a),
        .days       (days)
    );

    gjd_cycle_split u_cycle_split (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_a),
        .days    (days),
        .ctl_out (ctl_b),
        .q33     (q33),
        .q4      (q4),
        .rem4    (rem4)
    );

    gjd_year_month u_year_month (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl_in          (ctl_b),
        .q33             (q33),
        .q4              (q4),
        .rem4            (rem4),
        .done            (done),
        .jal_year        (jal_year),
        .jal_month       (jal_month),
        .jal_day         (jal_day),
        .jal_day_of_year (jal_day_of_year),
        .input_ok        (input_ok)
    );

endmodule

### test/jalali_date_checker.sv
// Checker for the date converter: predicts each request's Jalali date and compares results.
`timescale 1ns / 100ps

module jalali_date_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [13:0] greg_year,
    input  logic [3:0]  greg_month,
    input  logic [4:0]  greg_day,
    input  logic        done,
    input  logic [14:0] jal_year,
    input  logic [3:0]  jal_month,
    input  logic [4:0]  jal_day,
    input  logic [8:0]  jal_day_of_year,
    input  logic        input_ok,
    output int          mismatch_count,
    output int          pending_dates,
    output int          checked_dates
);

    typedef struct packed {
        logic [14:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [8:0]  doy;
        logic        ok;
    } jal_date_t;

    localparam longint GREG_CUM_DAYS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                             304, 334};

    jal_date_t expected_dates[$];

    function automatic jal_date_t convert_to_jalali(input logic [13:0] y_in,
                                                    input logic [3:0]  m_in,
                                                    input logic [4:0]  d_in);
        longint    gy;
        longint    gm;
        longint    gd;
        longint    gy_leap;
        longint    days;
        longint    jy;
        longint    jm;
        longint    jd;
        jal_date_t r;
        gy = longint'(y_in);
        gm = longint'(m_in);
        gd = longint'(d_in);
        r  = '0;
        if (gm < 1 || gm > 12 || gd < 1 || gd > 31)
            return r;
        gy_leap = (gm > 2) ? gy + 1 : gy;
        days = 355666 + 365 * gy + (gy_leap + 3) / 4 - (gy_leap + 99) / 100
             + (gy_leap + 399) / 400 + gd + GREG_CUM_DAYS[gm - 1];
        jy   = -1595 + 33 * (days / 12053);
        days = days % 12053;
        jy   = jy + 4 * (days / 1461);
        days = days % 1461;
        if (days > 365)
        begin
            jy   = jy + (days - 1) / 365;
            days = (days - 1) % 365;
        end
        if (days < 186)
        begin
            jm = 1 + days / 31;
            jd = 1 + days % 31;
        end
        else
        begin
            jm = 7 + (days - 186) / 30;
            jd = 1 + (days - 186) % 30;
        end
        r.year  = jy[14:0];
        r.month = jm[3:0];
        r.day   = jd[4:0];
        r.doy   = days[8:0];
        r.ok    = 1'b1;
        return r;
    endfunction

    task automatic compare_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        jal_date_t exp_date;
        if (!rst_n)
        begin
            expected_dates.delete();
            mismatch_count = 0;
            checked_dates  = 0;
            pending_dates  = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_dates.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, actual year %0d",
                             $time, $signed(jal_year));
                    mismatch_count++;
                end
                else
                begin
                    exp_date = expected_dates.pop_front();
                    compare_field("jal_year", longint'($signed(exp_date.year)),
                                  longint'($signed(jal_year)));
                    compare_field("jal_month", longint'(exp_date.month), longint'(jal_month));
                    compare_field("jal_day", longint'(exp_date.day), longint'(jal_day));
                    compare_field("jal_day_of_year", longint'(exp_date.doy),
                                  longint'(jal_day_of_year));
                    compare_field("input_ok", longint'(exp_date.ok), longint'(input_ok));
                    checked_dates++;
                end
            end
            if (start && !busy)
                expected_dates.push_back(convert_to_jalali(greg_year, greg_month, greg_day));
            pending_dates = expected_dates.size();
        end
    end

endmodule

### test/tb_gregorian_to_jalali_date.sv
// Testbench top for the Gregorian to Jalali date converter: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_gregorian_to_jalali_date;

    localparam int RANDOM_REQUESTS = 1030;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 16;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [13:0] greg_year;
    logic [3:0]  greg_month;
    logic [4:0]  greg_day;
    logic        done;
    logic [14:0] jal_year;
    logic [3:0]  jal_month;
    logic [4:0]  jal_day;
    logic [8:0]  jal_day_of_year;
    logic        input_ok;

    int mismatch_count;
    int pending_dates;
    int checked_dates;
    int request_count;
    int invalid_count;
    int stall_cycles;

    gregorian_to_jalali_date dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .greg_year       (greg_year),
        .greg_month      (greg_month),
        .greg_day        (greg_day),
        .done            (done),
        .jal_year        (jal_year),
        .jal_month       (jal_month),
        .jal_day         (jal_day),
        .jal_day_of_year (jal_day_of_year),
        .input_ok        (input_ok)
    );

    jalali_date_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .greg_year       (greg_year),
        .greg_month      (greg_month),
        .greg_day        (greg_day),
        .done            (done),
        .jal_year        (jal_year),
        .jal_month       (jal_month),
        .jal_day         (jal_day),
        .jal_day_of_year (jal_day_of_year),
        .input_ok        (input_ok),
        .mismatch_count  (mismatch_count),
        .pending_dates   (pending_dates),
        .checked_dates   (checked_dates)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: cycles with neither a request nor a result accepted
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_dates);
            $display("TB_ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d);
        logic taken;
        start      <= 1'b1;
        greg_year  <= y;
        greg_month <= m;
        greg_day   <= d;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        request_count++;
        if (m < 1 || m > 12 || d < 1)
            invalid_count++;
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic send_random_date();
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 60)
            y = 14'($urandom_range(1, 9999));
        else if (r < 85)
            y = 14'($urandom_range(1300, 2200));
        else
            y = 14'($urandom_range(0, 16383));
        m = 4'($urandom_range(1, 12));
        d = 5'($urandom_range(1, 31));
        r = $urandom_range(0, 99);
        if (r < 5)
            m = 4'($urandom_range(0, 15));
        else if (r < 10)
            d = 5'($urandom_range(0, 31));
        send_date(y, m, d);
    endtask

    initial
    begin
        int burst;
        rst_n         = 1'b0;
        start         = 1'b0;
        greg_year     = '0;
        greg_month    = '0;
        greg_day      = '0;
        request_count = 0;
        invalid_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_date(14'd0, 4'd1, 5'd1);
        send_date(14'd9999, 4'd12, 5'd31);
        send_date(14'd16383, 4'd15, 5'd31);
        send_date(14'd16383, 4'd12, 5'd31);
        send_date(14'd2024, 4'd0, 5'd10);
        send_date(14'd2024, 4'd13, 5'd10);
        send_date(14'd2024, 4'd6, 5'd0);
        send_date(14'd2024, 4'd0, 5'd0);
        send_date(14'd2024, 4'd3, 5'd19);
        send_date(14'd2024, 4'd3, 5'd20);
        send_date(14'd2024, 4'd3, 5'd21);
        idle_for(2);
        send_date(14'd2000, 4'd2, 5'd29);
        send_date(14'd1900, 4'd2, 5'd29);
        send_date(14'd1900, 4'd3, 5'd1);
        send_date(14'd2023, 4'd2, 5'd31);
        send_date(14'd2023, 4'd9, 5'd22);
        send_date(14'd2023, 4'd9, 5'd23);
        send_date(14'd2025, 4'd3, 5'd20);
        send_date(14'd2025, 4'd3, 5'd21);
        send_date(14'd1979, 4'd2, 5'd11);
        send_date(14'd621, 4'd3, 5'd22);
        send_date(14'd1, 4'd1, 5'd1);
        send_date(14'd2000, 4'd12, 5'd31);
        send_date(14'd2100, 4'd4, 5'd30);

        // hold off until everything outstanding has come back
        start <= 1'b0;
        while (pending_dates != 0)
            @(posedge clk);

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            send_random_date();
            if (burst > 0)
                burst--;
            else if ($urandom_range(0, 19) == 0)
                burst = $urandom_range(20, 50);
            else
                idle_for(pick_gap());
        end

        start <= 1'b0;
        while (pending_dates != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d date requests, %0d with an invalid month or day.",
                 request_count, invalid_count);
        $display("Checked %0d results, %0d field mismatches.", checked_dates, mismatch_count);
        if (mismatch_count == 0 && pending_dates == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### gregorian_to_jalali_date.f
sv/gjd_pkg.sv
sv/gjd_day_count.sv
sv/gjd_cycle_split.sv
sv/gjd_year_month.sv
sv/gregorian_to_jalali_date.sv
test/jalali_date_checker.sv
test/tb_gregorian_to_jalali_date.sv
